// ===== src/itp_pkg.sv =====
// Shared types, constants and precedence tables of the infix-to-postfix converter.
package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int IDX_W = $clog2(STACK_DEPTH);

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_MUL    = 8'h2A;
	localparam logic [7:0] CH_DIV    = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_BOTTOM = 8'h23;

	typedef logic signed [4:0] prec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic pop_emit;
		logic pop_drop;
		logic push;
		logic set_ovf;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic top_gt;
		logic top_eq;
		logic full;
		logic sp_zero;
		logic last;
		logic emit_ok;
		logic fin_ok;
	} sts_t;

	function automatic prec_t prec_on_stack(input logic [7:0] c);
		prec_t p;
		case (c) inside
			CH_PLUS, CH_MINUS:  p = 5'sd2;
			CH_MUL, CH_DIV:     p = 5'sd4;
			CH_CARET, CH_DOLLAR: p = 5'sd5;
			CH_LPAREN:          p = 5'sd0;
			CH_BOTTOM:          p = -5'sd1;
			default:            p = 5'sd8;
		endcase
		return p;
	endfunction

	function automatic prec_t prec_incoming(input logic [7:0] c);
		prec_t p;
		case (c) inside
			CH_PLUS, CH_MINUS:  p = 5'sd1;
			CH_MUL, CH_DIV:     p = 5'sd3;
			CH_CARET, CH_DOLLAR: p = 5'sd6;
			CH_LPAREN:          p = 5'sd9;
			CH_RPAREN:          p = 5'sd0;
			default:            p = 5'sd7;
		endcase
		return p;
	endfunction

endpackage

// ===== src/itp_ctrl.sv =====
// Sequencing state machine of the infix-to-postfix converter.
module itp_ctrl import itp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_POP;
				end
			end
			ST_POP: begin
				if (sts.top_gt) begin
					cmd.pop_emit = sts.emit_ok;
				end else begin
					// The pop loop is done: match a parenthesis, push, or drop on a full stack.
					if (sts.top_eq) begin
						cmd.pop_drop = 1'b1;
					end else if (!sts.full) begin
						cmd.push = 1'b1;
					end else begin
						cmd.set_ovf = 1'b1;
					end
					state_d = sts.last ? ST_FLUSH : ST_FINISH;
				end
			end
			ST_FLUSH: begin
				if (sts.sp_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.pop_emit = sts.emit_ok;
				end
			end
			ST_FINISH: begin
				if (sts.fin_ok) begin
					cmd.finish = 1'b1;
					in_stall   = 1'b0;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_d    = ST_POP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/itp_datapath.sv =====
// Operator stack, held result and output register of the infix-to-postfix converter.
module itp_datapath import itp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] symbol,
	input  logic       expression_last,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_symbol,
	output logic       out_valid,
	output logic       run_last,
	output logic       expression_end,
	output logic       overflow
);

	logic [7:0] stack_mem [STACK_DEPTH];

	logic [IDX_W-1:0] sp_q, sp_d, rd_addr;
	logic [7:0]       top_q;
	logic [7:0]       below_q;
	logic [7:0]       sym_q;
	logic             last_q;
	logic             ovf_q;
	logic             pend_valid_q;
	logic [7:0]       pend_sym_q;

	logic             res_valid_q;
	logic [7:0]       out_symbol_q;
	logic             out_valid_q;
	logic             run_last_q;
	logic             expression_end_q;
	logic             overflow_q;

	logic [7:0] top_eff;
	prec_t      top_prec, inc_prec;
	logic       out_free;
	logic       load_pend, load_final;

	// Entry zero is the bottom marker by position and is never stored.
	assign top_eff  = (sp_q == '0) ? CH_BOTTOM : top_q;
	assign top_prec = prec_on_stack(top_eff);
	assign inc_prec = prec_incoming(sym_q);
	assign out_free = !res_valid_q || !res_stall;

	assign sts.top_gt  = (sp_q != '0) && (top_prec > inc_prec);
	assign sts.top_eq  = (sp_q != '0) && (top_prec == inc_prec);
	assign sts.full    = (sp_q == IDX_W'(STACK_DEPTH - 1));
	assign sts.sp_zero = (sp_q == '0);
	assign sts.last    = last_q;
	assign sts.emit_ok = !pend_valid_q || out_free;
	assign sts.fin_ok  = out_free || !(pend_valid_q || last_q || ovf_q);

	assign load_pend  = cmd.pop_emit && pend_valid_q;
	assign load_final = cmd.finish && (pend_valid_q || last_q || ovf_q);

	always_comb begin
		sp_d = sp_q;
		if (cmd.pop_emit || cmd.pop_drop) begin
			sp_d = sp_q - 1'b1;
		end else if (cmd.push) begin
			sp_d = sp_q + 1'b1;
		end
		rd_addr = (sp_d == '0) ? '0 : sp_d - 1'b1;
	end

	// The read port always fetches the entry below the next top, so a pop refills the top at once.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[sp_q + 1'b1] <= sym_q;
		end
		below_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q         <= '0;
			ovf_q        <= 1'b0;
			last_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			sp_q <= sp_d;
			if (cmd.accept) begin
				ovf_q  <= 1'b0;
				last_q <= expression_last;
			end else if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.pop_emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end
			if (load_pend || load_final) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sym_q <= symbol;
		end
		if (cmd.push) begin
			top_q <= sym_q;
		end else if (cmd.pop_emit || cmd.pop_drop) begin
			top_q <= below_q;
		end
		if (cmd.pop_emit) begin
			pend_sym_q <= top_q;
		end
		// A dropped push marks each result loaded after it, flushed characters included.
		if (load_pend) begin
			out_symbol_q     <= pend_sym_q;
			out_valid_q      <= 1'b1;
			run_last_q       <= 1'b0;
			expression_end_q <= 1'b0;
			overflow_q       <= ovf_q;
		end else if (load_final) begin
			out_symbol_q     <= pend_valid_q ? pend_sym_q : 8'h00;
			out_valid_q      <= pend_valid_q;
			run_last_q       <= 1'b1;
			expression_end_q <= last_q;
			overflow_q       <= ovf_q;
		end
	end

	assign res_valid      = res_valid_q;
	assign out_symbol     = out_symbol_q;
	assign out_valid      = out_valid_q;
	assign run_last       = run_last_q;
	assign expression_end = expression_end_q;
	assign overflow       = overflow_q;

endmodule

// ===== src/infix_to_postfix_converter_unit.sv =====
// Top level of the infix-to-postfix converter: one character request in, postfix characters out.
// Each request carries one expression character; the unit keeps an operator stack with the bottom
// marker at entry zero and emits postfix characters on the result channel, each result marked with
// run_last on the last one a request causes, expression_end on the last one of a flushed expression,
// and overflow when a push found the stack full. The stack memory's single read port keeps the entry
// below the top ready, so that one pop retires per cycle while the result side does not stall.
// One emitted character is held back until the next is known, so the request's run_last flag
// can be set on it. A request that ends an expression always passes through the flush state,
// whether or not the stack still holds anything.
module infix_to_postfix_converter_unit import itp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] symbol,
	input  logic       expression_last,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_symbol,
	output logic       out_valid,
	output logic       run_last,
	output logic       expression_end,
	output logic       overflow
);

	cmd_t cmd;
	sts_t sts;

	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	itp_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.symbol          (symbol),
		.expression_last (expression_last),
		.cmd             (cmd),
		.sts             (sts),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.out_symbol      (out_symbol),
		.out_valid       (out_valid),
		.run_last        (run_last),
		.expression_end  (expression_end),
		.overflow        (overflow)
	);

endmodule
